// ===== src/nap_pkg.sv =====
// Package for the nearest active point search block.
// Holds table sizes, field widths, command codes and the payload and stage types.
// No dependencies.
package nap_pkg;

  localparam int MaxPoints = 256;
  localparam int CoordBits = 32;
  localparam int IndexBits = $clog2(MaxPoints);
  localparam int CountBits = 9;
  localparam int MagBits   = CoordBits;
  localparam int SqBits    = 2 * MagBits;
  localparam int SumBits   = SqBits + 1;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic                        command;
    logic [7:0]                  entry_index;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic                        active_flag;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] nearest_index;
  } out_item_t;

  // Tag that travels with one table read through the distance pipeline.
  typedef struct packed {
    logic                 valid;
    logic [IndexBits-1:0] idx;
  } tag_t;

  // Squared distance of one active entry, plus pipeline status.
  typedef struct packed {
    logic                 valid;
    logic                 busy;
    logic [IndexBits-1:0] idx;
    logic [SumBits-1:0]   sum;
  } dist_t;

endpackage

// ===== src/nap_if.sv =====
// Handshake channels of the nearest active point search block.
// Depends on nap_pkg for the payload types.
interface nap_in_if;
  logic              valid;
  logic              ready;
  nap_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nap_out_if;
  logic               valid;
  logic               ready;
  nap_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/nap_dist.sv =====
// Three-stage squared distance pipeline: difference magnitude, square, sum.
// Depends on nap_pkg.
module nap_dist (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nap_pkg::tag_t                        tag,
  input  logic signed [nap_pkg::CoordBits-1:0] qx,
  input  logic signed [nap_pkg::CoordBits-1:0] qy,
  input  logic signed [nap_pkg::CoordBits-1:0] px,
  input  logic signed [nap_pkg::CoordBits-1:0] py,
  output nap_pkg::dist_t                       cand
);

  logic signed [nap_pkg::CoordBits:0]   dx;
  logic signed [nap_pkg::CoordBits:0]   dy;
  logic [nap_pkg::CoordBits:0]          ax;
  logic [nap_pkg::CoordBits:0]          ay;

  logic                                 v1;
  logic [nap_pkg::IndexBits-1:0]        idx1;
  logic [nap_pkg::MagBits-1:0]          mag_x;
  logic [nap_pkg::MagBits-1:0]          mag_y;

  logic                                 v2;
  logic [nap_pkg::IndexBits-1:0]        idx2;
  logic [nap_pkg::SqBits-1:0]           sq_x;
  logic [nap_pkg::SqBits-1:0]           sq_y;

  logic                                 v3;
  logic [nap_pkg::IndexBits-1:0]        idx3;
  logic [nap_pkg::SumBits-1:0]          sum;

  // Differences are exact in one extra bit; their magnitude fits the coordinate width.
  always_comb begin
    dx = {qx[nap_pkg::CoordBits-1], qx} - {px[nap_pkg::CoordBits-1], px};
    dy = {qy[nap_pkg::CoordBits-1], qy} - {py[nap_pkg::CoordBits-1], py};
    ax = dx[nap_pkg::CoordBits] ? (nap_pkg::CoordBits+1)'(-dx) : (nap_pkg::CoordBits+1)'(dx);
    ay = dy[nap_pkg::CoordBits] ? (nap_pkg::CoordBits+1)'(-dy) : (nap_pkg::CoordBits+1)'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= tag.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx1  <= tag.idx;
    mag_x <= ax[nap_pkg::MagBits-1:0];
    mag_y <= ay[nap_pkg::MagBits-1:0];
    idx2  <= idx1;
    sq_x  <= nap_pkg::SqBits'(mag_x) * nap_pkg::SqBits'(mag_x);
    sq_y  <= nap_pkg::SqBits'(mag_y) * nap_pkg::SqBits'(mag_y);
    idx3  <= idx2;
    sum   <= {1'b0, sq_x} + {1'b0, sq_y};
  end

  assign cand.valid = v3;
  assign cand.busy  = v1 | v2 | v3;
  assign cand.idx   = idx3;
  assign cand.sum   = sum;

endmodule

// ===== src/nearest_active_point_search_top.sv =====
// Nearest active point search top level; depends on nap_pkg, nap_if and nap_dist.
// A write transfer updates the table and gives no result. A query loads its result
// once its scan is done: one memory read per scanned entry, up to min(point_count, 256)
// entries, then read, distance and drain stages; the drain ends sooner when the last entries are inactive.
// The result is offered in the cycle after it is loaded, when the next item can be taken; a result still
// waiting holds a new one back. Reset clears active flags, point_count and handshakes.
module nearest_active_point_search_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           point_count_we,
  input  logic [nap_pkg::CountBits-1:0]  point_count_data,
  nap_in_if.sink                         req,
  nap_out_if.source                      rsp
);

  // Controller states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam int CoordBits = nap_pkg::CoordBits;
  localparam int IndexBits = nap_pkg::IndexBits;
  localparam int CountBits = nap_pkg::CountBits;

  logic [1:0]                   state;
  logic [CountBits-1:0]         point_count;
  logic [CountBits-1:0]         limit;
  logic [CountBits-1:0]         scan_idx;
  logic signed [CoordBits-1:0]  qx;
  logic signed [CoordBits-1:0]  qy;

  // Coordinate memory: x in the upper half of a word, y in the lower half.
  logic [2*CoordBits-1:0]       coord_mem [nap_pkg::MaxPoints];
  logic [2*CoordBits-1:0]       rd_data;
  logic [nap_pkg::MaxPoints-1:0] active;

  nap_pkg::tag_t                rd_tag;
  nap_pkg::dist_t               cand;

  logic                         have;
  logic [nap_pkg::SumBits-1:0]  best_sum;
  logic [IndexBits-1:0]         best_idx;

  logic                         accept;
  logic                         issue;
  logic                         better;
  logic                         load_rsp;
  logic [CountBits-1:0]         count_clip;

  // Only one item is at work at a time; the result register lets a new item
  // be taken while the previous result still waits for its transfer.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign issue     = (state == S_SCAN) && (scan_idx != limit);

  // The result register is loaded once it is empty or is handing its result over.
  assign load_rsp  = (state == S_DONE) && (!rsp.valid || rsp.ready);

  // A count beyond the table scans the whole table.
  assign count_clip = (point_count > CountBits'(nap_pkg::MaxPoints))
                      ? CountBits'(nap_pkg::MaxPoints) : point_count;

  // Strictly smaller wins, so on a tie the earlier (lower) index is kept.
  assign better = cand.valid && (!have || (cand.sum < best_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (point_count_we) begin
      point_count <= point_count_data;
    end
  end

  // Table write; reads and writes never overlap because writes are only
  // accepted while no scan is running.
  always_ff @(posedge clk) begin
    if (accept && (req.payload.command == nap_pkg::CmdWrite)) begin
      coord_mem[req.payload.entry_index[IndexBits-1:0]] <=
        {req.payload.coord_x, req.payload.coord_y};
    end
    rd_data <= coord_mem[scan_idx[IndexBits-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (accept && (req.payload.command == nap_pkg::CmdWrite)) begin
      active[req.payload.entry_index[IndexBits-1:0]] <= req.payload.active_flag;
    end
  end

  // Inactive entries are dropped at the read stage and never reach the compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag.valid <= 1'b0;
    end else begin
      rd_tag.valid <= issue && active[scan_idx[IndexBits-1:0]];
    end
    rd_tag.idx <= scan_idx[IndexBits-1:0];
  end

  nap_dist u_dist (
    .clk  (clk),
    .rst  (rst),
    .tag  (rd_tag),
    .qx   (qx),
    .qy   (qy),
    .px   (rd_data[2*CoordBits-1:CoordBits]),
    .py   (rd_data[CoordBits-1:0]),
    .cand (cand)
  );

  // Query point and scan bounds are captured when the query transfer happens.
  always_ff @(posedge clk) begin
    if (accept && (req.payload.command == nap_pkg::CmdQuery)) begin
      qx    <= req.payload.coord_x;
      qy    <= req.payload.coord_y;
      limit <= count_clip;
    end
    if (better) begin
      best_sum <= cand.sum;
      best_idx <= cand.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_idx  <= '0;
      have      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !load_rsp) begin
        rsp.valid <= 1'b0;
      end
      if (better) begin
        have <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept && (req.payload.command == nap_pkg::CmdQuery)) begin
            scan_idx <= '0;
            have     <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Wait until the last read has passed the compare stage.
          if (!rd_tag.valid && !cand.busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_rsp) begin
            rsp.valid                 <= 1'b1;
            rsp.payload.found         <= have;
            rsp.payload.nearest_index <= have ? 8'(best_idx) : 8'd0;
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for nearest_active_point_search_top: directed corner cases, then
// random table writes and queries, checked against an in-bench model of the point table.
// Depends on nap_pkg, the nap_in_if/nap_out_if interfaces and the top-level RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [nap_pkg::CoordBits-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [nap_pkg::CoordBits-1:0] CoordMax = 32'sh7FFF_FFFF;
  // A query scans at most 256 entries, so the settle time leaves a comfortable margin.
  localparam int SettleCycles   = 300;
  localparam int LongHoldCycles = 600;
  localparam int MaxReports     = 50;

  // Coordinate distributions for the random part.
  typedef enum int {SpreadWide, SpreadNear, SpreadEdge, SpreadMixed} spread_e;

  logic                          clk;
  logic                          rst;
  logic                          point_count_we;
  logic [nap_pkg::CountBits-1:0] point_count_data;

  nap_in_if  req_ch ();
  nap_out_if rsp_ch ();

  nearest_active_point_search_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .point_count_we   (point_count_we),
    .point_count_data (point_count_data),
    .req              (req_ch),
    .rsp              (rsp_ch)
  );

  // Items waiting to be offered to the block, and query answers waiting to come back.
  nap_pkg::in_item_t  pending_items[$];
  nap_pkg::out_item_t expected_nearest[$];

  // Model of the block's state. It is updated when a transfer is accepted, so it
  // always matches what the block has seen, not what is still queued.
  logic [nap_pkg::CountBits-1:0]        scan_count;
  logic signed [nap_pkg::CoordBits-1:0] table_x[nap_pkg::MaxPoints];
  logic signed [nap_pkg::CoordBits-1:0] table_y[nap_pkg::MaxPoints];
  logic                                 table_active[nap_pkg::MaxPoints];

  // The stimulus side keeps its own copy of the coordinates it has queued, so that
  // queries can be aimed close to stored points.
  logic signed [nap_pkg::CoordBits-1:0] aim_x[nap_pkg::MaxPoints];
  logic signed [nap_pkg::CoordBits-1:0] aim_y[nap_pkg::MaxPoints];

  int          fail_count;
  int          req_idle_pct;
  int          rsp_idle_pct;
  bit          want_long_hold;
  bit          long_hold_done;
  int unsigned req_gap_left;
  int unsigned rsp_gap_left;
  int unsigned long_hold_left;

  // Clock generator: 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Squared distance along one axis. The difference needs 33 bits, its magnitude
  // fits in 32 bits, and the square in 64; the caller adds two of them in 66 bits,
  // so the sum of two near-maximal squares keeps its carry.
  function automatic logic [65:0] axis_square(logic signed [nap_pkg::CoordBits-1:0] a,
                                              logic signed [nap_pkg::CoordBits-1:0] b);
    logic signed [nap_pkg::CoordBits:0] diff;
    logic [63:0]                        mag;
    diff = $signed({a[nap_pkg::CoordBits-1], a}) - $signed({b[nap_pkg::CoordBits-1], b});
    mag  = {31'b0, (diff[nap_pkg::CoordBits] ? -diff : diff)};
    return {2'b00, mag * mag};
  endfunction

  // Applies one accepted item to the table model. A write updates one entry; a
  // query scans the active entries below the count and queues the expected answer.
  // Strictly smaller distances replace the best, so ties keep the lowest index.
  task automatic apply_command(nap_pkg::in_item_t item);
    nap_pkg::out_item_t answer;
    logic [65:0]        best_dist;
    logic [65:0]        cand_dist;
    int                 span;
    if (item.command == nap_pkg::CmdWrite) begin
      // An 8-bit index can never point past the 256-entry table.
      table_x[item.entry_index]      = item.coord_x;
      table_y[item.entry_index]      = item.coord_y;
      table_active[item.entry_index] = item.active_flag;
    end else begin
      answer    = '0;
      best_dist = '0;
      span      = (scan_count > nap_pkg::MaxPoints) ? nap_pkg::MaxPoints : int'(scan_count);
      for (int i = 0; i < span; i++) begin
        if (!table_active[i]) continue;
        cand_dist = axis_square(item.coord_x, table_x[i])
                    + axis_square(item.coord_y, table_y[i]);
        if (!answer.found || cand_dist < best_dist) begin
          answer.found         = 1'b1;
          answer.nearest_index = i[7:0];
          best_dist            = cand_dist;
        end
      end
      expected_nearest.push_back(answer);
    end
  endtask

  function automatic void report_mismatch(string field, logic [7:0] want, logic [7:0] got);
    fail_count++;
    if (fail_count <= MaxReports)
      $error("mismatch on %s: expected %0d, got %0d", field, want, got);
  endfunction

  function automatic logic [nap_pkg::CoordBits-1:0] pick_coord(spread_e spread);
    spread_e kind;
    kind = (spread == SpreadMixed) ? spread_e'($urandom_range(0, 2)) : spread;
    case (kind)
      SpreadNear: begin
        return 32'($urandom_range(0, 16)) - 32'd8;
      end
      SpreadEdge: begin
        case ($urandom_range(0, 6))
          0: return CoordMin;
          1: return CoordMin + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return CoordMax - 1;
          default: return CoordMax;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic queue_item(logic cmd, logic [7:0] idx, logic [nap_pkg::CoordBits-1:0] x,
                            logic [nap_pkg::CoordBits-1:0] y, logic act);
    nap_pkg::in_item_t item;
    item.command     = cmd;
    item.entry_index = idx;
    item.coord_x     = x;
    item.coord_y     = y;
    item.active_flag = act;
    if (cmd == nap_pkg::CmdWrite) begin
      aim_x[idx] = x;
      aim_y[idx] = y;
    end
    pending_items.push_back(item);
  endtask

  // Random traffic: roughly half writes, mostly into the scanned range so that
  // queries see a populated table, and half queries, a third of them aimed just
  // next to a stored point so that close calls and ties come up often.
  task automatic queue_random_items(int count, spread_e spread);
    int          span;
    int          pick;
    logic [7:0]  idx;
    logic [31:0] qx;
    logic [31:0] qy;
    span = (scan_count > nap_pkg::MaxPoints) ? nap_pkg::MaxPoints : int'(scan_count);
    for (int k = 0; k < count; k++) begin
      idx = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 45) begin
        if (span != 0 && $urandom_range(0, 3) != 0) idx = 8'($urandom_range(0, span - 1));
        queue_item(nap_pkg::CmdWrite, idx, pick_coord(spread), pick_coord(spread),
                   $urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 2) == 0) begin
        pick = (span != 0) ? $urandom_range(0, span - 1) : 0;
        qx   = aim_x[pick] + 32'($urandom_range(0, 4)) - 32'd2;
        qy   = aim_y[pick] + 32'($urandom_range(0, 4)) - 32'd2;
        queue_item(nap_pkg::CmdQuery, idx, qx, qy, 1'($urandom_range(0, 1)));
      end else begin
        queue_item(nap_pkg::CmdQuery, idx, pick_coord(spread), pick_coord(spread),
                   1'($urandom_range(0, 1)));
      end
    end
  endtask

  // The count register is only written while the block is idle, so the model can
  // take the new value at once.
  task automatic set_point_count(int unsigned value);
    @(posedge clk);
    point_count_we   <= 1'b1;
    point_count_data <= value[nap_pkg::CountBits-1:0];
    @(posedge clk);
    point_count_we   <= 1'b0;
    scan_count = value[nap_pkg::CountBits-1:0];
  endtask

  // Waits until every queued item has been transferred and every answer has come
  // back, then lets the block settle before the next phase.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || req_ch.valid || expected_nearest.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Request driver. When the current item has been transferred (or there is none),
  // it either starts an idle burst of random length or offers the next pending item.
  // The valid line gets exactly one assignment per edge, so back-to-back transfers
  // keep it high without a glitch.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      req_gap_left   <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_command(req_ch.payload);
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap_left != 0) begin
          req_ch.valid <= 1'b0;
          req_gap_left <= req_gap_left - 1;
        end else if (pending_items.size() != 0 && $urandom_range(0, 99) < req_idle_pct) begin
          req_ch.valid <= 1'b0;
          req_gap_left <= $urandom_range(0, 4);
        end else if (pending_items.size() != 0) begin
          req_ch.valid   <= 1'b1;
          req_ch.payload <= pending_items.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and ready control. Each transfer is checked field by field
  // against the oldest expected answer. Ready drops in short random bursts, and
  // once, on request, for a long stretch so that the block backs up and stalls
  // its request side while the driver keeps offering items.
  always @(posedge clk) begin
    nap_pkg::out_item_t want;
    if (rst) begin
      rsp_ch.ready   <= 1'b0;
      rsp_gap_left   <= 0;
      long_hold_left <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_nearest.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $error("result transfer with no query outstanding: found %0d, index %0d",
                   rsp_ch.payload.found, rsp_ch.payload.nearest_index);
        end else begin
          want = expected_nearest.pop_front();
          if (rsp_ch.payload.found !== want.found)
            report_mismatch("found", want.found, rsp_ch.payload.found);
          if (rsp_ch.payload.nearest_index !== want.nearest_index)
            report_mismatch("nearest_index", want.nearest_index,
                            rsp_ch.payload.nearest_index);
        end
      end
      if (want_long_hold && !long_hold_done) begin
        rsp_ch.ready   <= 1'b0;
        long_hold_left <= LongHoldCycles;
        long_hold_done <= 1'b1;
      end else if (long_hold_left != 0) begin
        rsp_ch.ready   <= 1'b0;
        long_hold_left <= long_hold_left - 1;
      end else if (rsp_gap_left != 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_gap_left <= rsp_gap_left - 1;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
        rsp_ch.ready <= 1'b0;
        rsp_gap_left <= $urandom_range(0, 4);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed corner cases, then random phases at a range of
  // scan counts including zero, one and counts beyond the table size.
  initial begin
    rst              = 1'b1;
    point_count_we   = 1'b0;
    point_count_data = '0;
    req_ch.valid     = 1'b0;
    req_ch.payload   = '0;
    rsp_ch.ready     = 1'b0;
    fail_count       = 0;
    want_long_hold   = 1'b0;
    req_idle_pct     = 20;
    rsp_idle_pct     = 20;
    scan_count       = '0;
    for (int i = 0; i < nap_pkg::MaxPoints; i++) begin
      table_x[i]      = '0;
      table_y[i]      = '0;
      table_active[i] = 1'b0;
      aim_x[i]        = '0;
      aim_y[i]        = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_point_count(nap_pkg::MaxPoints);
    // An empty table answers with found low.
    queue_item(nap_pkg::CmdQuery, 8'd0, 0, 0, 1'b0);
    // Three corners of the coordinate range, plus one inactive entry.
    queue_item(nap_pkg::CmdWrite, 8'd0, CoordMin, CoordMin, 1'b1);
    queue_item(nap_pkg::CmdWrite, 8'd255, CoordMax, CoordMax, 1'b1);
    queue_item(nap_pkg::CmdWrite, 8'd3, CoordMin, CoordMax, 1'b1);
    queue_item(nap_pkg::CmdWrite, 8'd7, 0, 0, 1'b0);
    queue_item(nap_pkg::CmdQuery, 8'd0, CoordMax, CoordMax, 1'b0);
    queue_item(nap_pkg::CmdQuery, 8'd0, CoordMin, CoordMin, 1'b0);
    queue_item(nap_pkg::CmdQuery, 8'd0, 0, 0, 1'b0);
    // Clearing the top entry leaves one candidate whose squared distance carries
    // past 64 bits, and one just below that.
    queue_item(nap_pkg::CmdWrite, 8'd255, CoordMax, CoordMax, 1'b0);
    queue_item(nap_pkg::CmdQuery, 8'd255, CoordMax, CoordMax, 1'b1);
    // Equal distances: the lower index has to win.
    queue_item(nap_pkg::CmdQuery, 8'd0, CoordMax, CoordMin, 1'b0);
    queue_item(nap_pkg::CmdWrite, 8'd10, 5, -5, 1'b1);
    queue_item(nap_pkg::CmdWrite, 8'd20, 5, -5, 1'b1);
    queue_item(nap_pkg::CmdQuery, 8'd0, 5, -5, 1'b0);
    queue_item(nap_pkg::CmdWrite, 8'd10, 5, -5, 1'b0);
    queue_item(nap_pkg::CmdQuery, 8'd0, 5, -5, 1'b0);
    queue_item(nap_pkg::CmdQuery, 8'd0, 4, -5, 1'b0);
    queue_item(nap_pkg::CmdWrite, 8'd200, -1, -1, 1'b1);
    queue_item(nap_pkg::CmdQuery, 8'd255, -1, 0, 1'b1);
    wait_drained();

    // A zero count hides every entry, even active ones.
    set_point_count(0);
    queue_random_items(100, SpreadMixed);
    wait_drained();

    set_point_count(1);
    queue_random_items(100, SpreadNear);
    wait_drained();

    // The largest count the register holds still scans only the table.
    req_idle_pct = 30;
    rsp_idle_pct = 10;
    set_point_count(511);
    queue_random_items(150, SpreadMixed);
    wait_drained();

    // Short queries and a long receiver stall to back the block up.
    req_idle_pct   = 5;
    rsp_idle_pct   = 20;
    want_long_hold = 1'b1;
    set_point_count(16);
    queue_random_items(300, SpreadNear);
    wait_drained();

    req_idle_pct = 15;
    rsp_idle_pct = 35;
    set_point_count(5);
    queue_random_items(280, SpreadEdge);
    wait_drained();

    req_idle_pct = 20;
    rsp_idle_pct = 20;
    set_point_count(257);
    queue_random_items(150, SpreadWide);
    wait_drained();

    set_point_count(40);
    queue_random_items(300, SpreadMixed);
    wait_drained();

    // Final stretch runs at full rate on both sides.
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    set_point_count(8);
    queue_random_items(250, SpreadNear);
    wait_drained();

    if (fail_count == 0) begin
      $display("[nearest_active_point_search_top] OK");
    end else begin
      $display("[nearest_active_point_search_top] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #40_000_000;
    $display("[nearest_active_point_search_top] ERROR");
    $finish;
  end

endmodule
